// ----- rtl/psr_pkg.sv -----
// psr_pkg: shared types and constants for the PSI section reassembler.
// No dependencies.
`default_nettype none
package psr_pkg;
   localparam int STORE_DEPTH  = 4096;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int PACKET_BYTES = 188;
   localparam logic [12:0] MAXLEN_RESET = 13'd1024;
   localparam int QDEPTH       = 4;

   typedef enum logic [2:0] {
      PH_HEADER, PH_ADAPT, PH_PAYLOAD, PH_PTRDATA, PH_SECTIONS, PH_CONT, PH_DONE
   } phase_type;

   // Work for the back end: an optional store write and an optional result.
   typedef struct packed {
      logic              wr;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              rd;
      logic [ADDR_W-1:0] raddr;
      logic              done;
      logic [12:0]       len;
   } op_type;
endpackage
`default_nettype wire

// ----- rtl/psr_front.sv -----
// psr_front: packet parser; classifies each beat into store/read/report ops.
// Depends on psr_pkg. Keeps section header bytes 1 and 2 in a shadow copy.
`default_nettype none
module psr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            valid,
   input  wire logic            mode,
   input  wire logic [7:0]      data_byte,
   input  wire logic            packet_start,
   input  wire logic [11:0]     read_index,
   input  wire logic [12:0]     max_len,
   output psr_pkg::op_type      op,
   output logic                 op_valid
);
   logic [7:0]  pos_ff, pos_in;
   logic [12:0] fill_ff, fill_in, exp_ff, exp_in;
   logic [3:0]  lastcc_ff, lastcc_in;
   logic [6:0]  hdr_ff, hdr_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic        ign_ff, ign_in;
   psr_pkg::phase_type ph_ff, ph_in;
   logic [7:0]  h1_ff, h1_in, h2_ff, h2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; fill_ff <= '0; exp_ff <= '0; lastcc_ff <= '0;
         hdr_ff <= '0; ptr_ff <= '0; ign_ff <= 1'b0; ph_ff <= psr_pkg::PH_HEADER;
         h1_ff <= '0; h2_ff <= '0;
      end else begin
         pos_ff <= pos_in; fill_ff <= fill_in; exp_ff <= exp_in;
         lastcc_ff <= lastcc_in; hdr_ff <= hdr_in; ptr_ff <= ptr_in;
         ign_ff <= ign_in; ph_ff <= ph_in; h1_ff <= h1_in; h2_ff <= h2_in;
      end
   end

   always_comb begin
      logic [7:0]  p;
      logic        live, cont_ok, go_cont, sect, stuff;
      logic [12:0] hl, nf;
      logic [7:0]  n1, n2;
      pos_in = pos_ff; fill_in = fill_ff; exp_in = exp_ff; lastcc_in = lastcc_ff;
      hdr_in = hdr_ff; ptr_in = ptr_ff; ign_in = ign_ff; ph_in = ph_ff;
      h1_in = h1_ff; h2_in = h2_ff;
      op = '0; op_valid = 1'b0;
      p = pos_ff; live = 1'b1; go_cont = 1'b0; sect = 1'b0;
      n1 = h1_ff; n2 = h2_ff; hl = '0; nf = '0; stuff = 1'b0;
      cont_ok = (lastcc_ff + 4'd1) == hdr_ff[3:0];
      if (valid && mode) begin
         op_valid = 1'b1; op.rd = 1'b1; op.raddr = read_index[psr_pkg::ADDR_W-1:0];
      end else if (valid) begin
         if (packet_start) begin
            if (pos_ff != 8'd0 && pos_ff < 8'(psr_pkg::PACKET_BYTES) && !ign_ff) begin
               fill_in = '0; exp_in = '0;
            end
            p = '0; ign_in = 1'b0; ph_in = psr_pkg::PH_HEADER;
         end
         if (p >= 8'(psr_pkg::PACKET_BYTES)) live = 1'b0;
         if (live && !ign_in) begin
            unique case (ph_in)
               psr_pkg::PH_HEADER: begin
                  if (p == 8'd0) hdr_in = '0;
                  else if (p == 8'd1) hdr_in = {data_byte[6], hdr_in[5:0]};
                  else if (p == 8'd3) begin
                     hdr_in = {hdr_in[6], data_byte[5:0]};
                     if (data_byte[5:4] == 2'b01) ph_in = psr_pkg::PH_PAYLOAD;
                     else if (data_byte[5:4] != 2'b11) ign_in = 1'b1;
                  end else if (p == 8'd4) begin
                     if (data_byte >= 8'(psr_pkg::PACKET_BYTES - 5)) ign_in = 1'b1;
                     else begin
                        ptr_in = data_byte;
                        ph_in = (data_byte != 0) ? psr_pkg::PH_ADAPT : psr_pkg::PH_PAYLOAD;
                     end
                  end
               end
               psr_pkg::PH_ADAPT: begin
                  ptr_in = ptr_ff - 8'd1;
                  if (ptr_in == 0) ph_in = psr_pkg::PH_PAYLOAD;
               end
               psr_pkg::PH_PAYLOAD: begin
                  if (hdr_in[6]) begin
                     if (data_byte > 8'(psr_pkg::PACKET_BYTES - 1) - p) begin
                        fill_in = '0; exp_in = '0; ign_in = 1'b1;
                     end else if (data_byte != 0) begin
                        if (fill_ff != 0 && !cont_ok) begin
                           fill_in = '0; exp_in = '0; ign_in = 1'b1;
                        end else begin
                           ptr_in = data_byte; ph_in = psr_pkg::PH_PTRDATA;
                        end
                     end else begin
                        fill_in = '0; exp_in = '0; ph_in = psr_pkg::PH_SECTIONS;
                     end
                  end else if (fill_ff == 0) ign_in = 1'b1;
                  else if (!cont_ok || (exp_ff == 0 && fill_ff >= 13'd3)) begin
                     fill_in = '0; exp_in = '0; ign_in = 1'b1;
                  end else begin
                     ph_in = psr_pkg::PH_CONT; go_cont = 1'b1;
                  end
               end
               psr_pkg::PH_PTRDATA: begin
                  nf = fill_ff;
                  if (fill_ff != 0) begin
                     op_valid = fill_ff < 13'(psr_pkg::STORE_DEPTH);
                     op.wr = op_valid;
                     op.waddr = fill_ff[psr_pkg::ADDR_W-1:0]; op.wdata = data_byte;
                     if (fill_ff == 13'd1) n1 = data_byte;
                     if (fill_ff == 13'd2) n2 = data_byte;
                     nf = fill_ff + 13'd1;
                  end
                  fill_in = nf;
                  ptr_in = ptr_ff - 8'd1;
                  if (ptr_in == 0) begin
                     hl = {1'b0, n1[3:0], n2} + 13'd3;
                     if (nf != 0) begin
                        if (exp_ff == 0 && nf >= 13'd3 && hl > 13'd3 && hl <= max_len
                            && hl <= 13'(psr_pkg::STORE_DEPTH)) exp_in = hl;
                        if (exp_in == 0 || exp_in != nf) ign_in = 1'b1;
                        else begin
                           op_valid = 1'b1; op.done = 1'b1; op.len = exp_in;
                        end
                     end
                     fill_in = '0; exp_in = '0;
                     if (!ign_in) ph_in = psr_pkg::PH_SECTIONS;
                  end
               end
               psr_pkg::PH_SECTIONS: begin
                  if (fill_ff == 0 && data_byte == 8'hff) begin
                     ph_in = psr_pkg::PH_DONE; stuff = 1'b1;
                  end else sect = 1'b1;
               end
               psr_pkg::PH_CONT: go_cont = 1'b1;
               default: ;
            endcase
            // Shared section byte store / length check / completion
            if (go_cont || sect) begin
               op.wr = fill_ff < 13'(psr_pkg::STORE_DEPTH);
               op_valid = op.wr;
               op.waddr = fill_ff[psr_pkg::ADDR_W-1:0]; op.wdata = data_byte;
               if (fill_ff == 13'd1) n1 = data_byte;
               if (fill_ff == 13'd2) n2 = data_byte;
               nf = fill_ff + 13'd1;
               fill_in = nf;
               hl = {1'b0, n1[3:0], n2} + 13'd3;
               if (exp_ff == 0 && nf == 13'd3) begin
                  if (hl <= 13'd3 || hl > max_len || hl > 13'(psr_pkg::STORE_DEPTH)) begin
                     fill_in = '0; exp_in = '0;
                     if (go_cont) ign_in = 1'b1; else ph_in = psr_pkg::PH_DONE;
                  end else exp_in = hl;
               end
               if (fill_in != 0 && exp_in != 0 && nf == exp_in) begin
                  op_valid = 1'b1; op.done = 1'b1; op.len = exp_in;
                  fill_in = '0; exp_in = '0;
                  if (go_cont) ph_in = psr_pkg::PH_DONE;
               end
            end
         end
         if (live) begin
            if (p == 8'(psr_pkg::PACKET_BYTES - 1) && !ign_in) lastcc_in = hdr_in[3:0];
            pos_in = p + 8'd1;
         end
         h1_in = n1; h2_in = n2;
      end
      if (stuff) op_valid = 1'b0;
   end
endmodule
`default_nettype wire

// ----- rtl/psr_back.sv -----
// psr_back: section store RAM and registered result stage.
// Depends on psr_pkg. Takes ops from the queue; read data is registered.
`default_nettype none
module psr_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            op_valid,
   input  wire psr_pkg::op_type op,
   output logic                 op_ready,
   input  wire logic            pop,
   output logic                 empty,
   output logic                 kind,
   output logic [12:0]          section_length,
   output logic [7:0]           read_data
);
   logic [7:0] mem [psr_pkg::STORE_DEPTH];
   logic       vld_ff, kind_ff;
   logic [12:0] len_ff;
   logic [7:0] rd_ff;
   logic       take;

   assign op_ready = !vld_ff || pop;
   assign take = op_valid && op_ready;

   // store port: write and registered read
   always_ff @(posedge clock) begin
      if (take && op.wr) mem[op.waddr] <= op.wdata;
      if (take && op.rd) rd_ff <= mem[op.raddr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (op_ready) vld_ff <= take && (op.rd || op.done);
   end
   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= op.done;
         len_ff  <= op.done ? op.len : 13'd0;
      end
   end

   assign empty = !vld_ff;
   assign kind = kind_ff;
   assign section_length = len_ff;
   assign read_data = kind_ff ? 8'd0 : rd_ff;
endmodule
`default_nettype wire

// ----- rtl/psi_section_reassembler.sv -----
// PSI section reassembler top: parser front, op queue, store/result back.
// A request passes through the op queue and then the result register to reach the rsp ports.
// Throughput one beat per cycle while pop keeps up; an unpopped result stalls the
// back, and full rises once 3 ops wait in the queue. Synchronous active-high reset
// clears parser state, queue and result; the section store is not cleared and
// max_section_length resets to 1024. Depends on psr_pkg, psr_front, psr_back.
`default_nettype none
module psi_section_reassembler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_packet_start,
   input  wire logic [11:0] req_read_index,
   input  wire logic        pop,
   output logic             empty,
   output logic             rsp_kind,
   output logic [12:0]      rsp_section_length,
   output logic [7:0]       rsp_read_data,
   input  wire logic        csr_we,
   input  wire logic [12:0] csr_wdata
);
   logic [12:0] maxlen_ff;
   psr_pkg::op_type fop, q_ff [psr_pkg::QDEPTH];
   logic fvalid, bready;
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic qpush, qpop;

   always_ff @(posedge clock) begin
      if (reset) maxlen_ff <= psr_pkg::MAXLEN_RESET;
      else if (csr_we) maxlen_ff <= csr_wdata;
   end

   assign full = cnt_ff >= 3'(psr_pkg::QDEPTH - 1);

   psr_front u_front (.clock, .reset, .valid(push && !full), .mode(req_mode),
      .data_byte(req_data_byte), .packet_start(req_packet_start),
      .read_index(req_read_index), .max_len(maxlen_ff), .op(fop), .op_valid(fvalid));

   // op queue between front and back
   assign qpush = fvalid;
   assign qpop  = cnt_ff != 0 && bready;
   always_ff @(posedge clock) begin
      if (qpush) q_ff[wp_ff] <= fop;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (qpush) wp_ff <= wp_ff + 2'd1;
         if (qpop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(qpush) - 3'(qpop);
      end
   end

   psr_back u_back (.clock, .reset, .op_valid(cnt_ff != 0), .op(q_ff[rp_ff]),
      .op_ready(bready), .pop, .empty, .kind(rsp_kind),
      .section_length(rsp_section_length), .read_data(rsp_read_data));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'(psr_pkg::QDEPTH) |-> !qpush) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(psr_pkg::QDEPTH)) else $error("queue count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty) else $error("result lost");
endmodule
`default_nettype wire
